>>> rtl/setp_pkg.sv
// ============================================================================
// setp_pkg: shared types and constants for the edge trigger plotter
// Holds the register index codes, slope codes, fixed field widths, the
// sequencer state type and the divider status struct.
// ============================================================================
package setp_pkg;

    // Frame positions, point counts and divisors share one width.
    localparam int POS_W      = 13;
    // Fractional bits of the horizontal position.
    localparam int FRAC_W     = 16;
    localparam int STEP_CNT_W = $clog2(FRAC_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LEVEL_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 2'd3;

    // Slope modes; the unused code behaves as free running.
    localparam logic [1:0] SLOPE_FREE = 2'd0;
    localparam logic [1:0] SLOPE_RISE = 2'd1;
    localparam logic [1:0] SLOPE_FALL = 2'd2;

    localparam logic [POS_W-1:0] FRAME_LENGTH_RST = 13'd1024;

    // Half scale, subtracted from the quotient to centre x on zero.
    localparam logic [FRAC_W-1:0] HALF_SCALE = 16'h8000;
    localparam logic [FRAC_W-1:0] QUOT_SAT   = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> rtl/setp_div.sv
// ============================================================================
// setp_div: bit-serial fractional divider
// Computes floor(rem * 2^FRAC_W / divisor) for rem below divisor, one
// quotient bit per cycle with a single shared compare and subtract.
// ============================================================================
module setp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [setp_pkg::POS_W-1:0]   i_rem,
    input  logic [setp_pkg::POS_W-1:0]   i_divisor,
    output setp_pkg::t_div_status        o_status,
    output logic [setp_pkg::FRAC_W-1:0]  o_quot
);
    import setp_pkg::*;

    logic [POS_W-1:0]      r_rem,   n_rem;
    logic [POS_W-1:0]      r_div;
    logic [FRAC_W-1:0]     r_quot,  n_quot;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [POS_W:0]        w_trial;
    logic                  w_fits;

    // Shift the partial remainder up one place and try the divisor against it.
    assign w_trial = {r_rem, 1'b0};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_rem  = w_fits ? POS_W'(w_trial - {1'b0, r_div}) : POS_W'(w_trial);
        n_quot = {r_quot[FRAC_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

>>> rtl/scope_edge_trigger_plotter.sv
// ============================================================================
// scope_edge_trigger_plotter: oscilloscope edge trigger trace builder
// Groups signed samples into frames, finds the trigger edge and turns each
// plotted sample into an (x, y) point with x scaled across the frame.
// ============================================================================
// Usage
// The input channel takes one signed sample word per handshake (valid high,
// stall low). Every sample yields exactly one result word on the output
// channel: point_valid, x_pos, y_pos and frame_end. Configuration is written
// through a separate valid/ready port (ready is always high) and must only be
// changed while the block is idle.
// A sample that is not plotted or whose position saturates goes from the
// sequencer's idle state straight to its output state; a plotted point
// first waits in the divide state, since its x position goes through a
// bit-serial divider producing one of the 16 quotient bits per cycle. The
// block holds its input stall high while a sample is being worked on, so it
// takes a new sample only once the last one's word has left the sequencer.
// A finished word sits in an output register, so the next sample can already
// be taken while the receiver still stalls; a word that is ready while the
// register is full waits in the sequencer until the register frees.
// Reset clears the frame position, trigger state, point count, the previous
// sample and the output valid flag, and loads the register reset values.
// ============================================================================
module scope_edge_trigger_plotter #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    // Result output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_point_valid,
    output logic signed [setp_pkg::FRAC_W-1:0] o_x_pos,
    output logic signed [SAMPLE_BITS-2:0]     o_y_pos,
    output logic                              o_frame_end,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [setp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [setp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import setp_pkg::*;

    // Width used to compare samples against the 16-bit trigger level.
    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam logic [31:0] MAX_FRAME_W = MAX_FRAME;

    // Configuration registers
    logic [1:0]               r_slope_mode;
    logic signed [LEVEL_W-1:0] r_trigger_level;
    logic [POS_W-1:0]         r_point_limit;
    logic [POS_W-1:0]         r_frame_length;

    // Frame and trigger state
    logic signed [SAMPLE_BITS-1:0] r_prev_sample;
    logic                     r_have_prev;
    logic                     r_triggered;
    logic [POS_W-1:0]         r_frame_pos;
    logic [POS_W-1:0]         r_trigger_pos;
    logic [POS_W-1:0]         r_points;

    // Per-sample working registers
    t_seq_state               r_state;
    logic                     r_valid_pt;
    logic                     r_last;
    logic                     r_sat;
    logic [SAMPLE_BITS-2:0]   r_y;

    // Output register
    logic                     r_out_valid;
    logic                     r_out_point;
    logic [FRAC_W-1:0]        r_out_x;
    logic [SAMPLE_BITS-2:0]   r_out_y;
    logic                     r_out_last;

    // Combinational decisions made as a sample is accepted
    logic                     w_accept;
    logic [POS_W-1:0]         w_len;
    logic signed [CMP_W-1:0]  w_s;
    logic signed [CMP_W-1:0]  w_p;
    logic signed [CMP_W-1:0]  w_lev;
    logic                     w_trig_mode;
    logic                     w_hit;
    logic                     w_trig_now;
    logic [POS_W-1:0]         w_origin;
    logic                     w_active;
    logic                     w_valid;
    logic [POS_W-1:0]         w_off;
    logic [POS_W-1:0]         w_divisor;
    logic                     w_sat;
    logic                     w_last;
    logic                     w_div_start;
    logic                     w_out_free;
    logic [FRAC_W-1:0]        w_quot;
    logic [FRAC_W-1:0]        w_q_final;
    t_div_status              w_div_st;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_mode    <= SLOPE_FREE;
            r_trigger_level <= '0;
            r_point_limit   <= '0;
            r_frame_length  <= FRAME_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SLOPE_MODE:    r_slope_mode    <= i_cfg_data[1:0];
                CFG_TRIGGER_LEVEL: r_trigger_level <= signed'(i_cfg_data[LEVEL_W-1:0]);
                CFG_POINT_LIMIT:   r_point_limit   <= i_cfg_data[POS_W-1:0];
                CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg_data[POS_W-1:0];
                default:           r_slope_mode    <= r_slope_mode;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Trigger and framing decisions for the sample being accepted
    // ------------------------------------------------------------------
    always_comb begin
        // Effective frame length: a zero length counts as one, and the
        // length is capped at the largest frame the block supports.
        if (r_frame_length == '0) begin
            w_len = POS_W'(1);
        end else if (32'(r_frame_length) > MAX_FRAME_W) begin
            w_len = POS_W'(MAX_FRAME);
        end else begin
            w_len = r_frame_length;
        end

        w_s   = CMP_W'(i_sample);
        w_p   = CMP_W'(r_prev_sample);
        w_lev = CMP_W'(r_trigger_level);

        w_trig_mode = (r_slope_mode == SLOPE_RISE) || (r_slope_mode == SLOPE_FALL);
        if (r_slope_mode == SLOPE_RISE) begin
            w_hit = (w_p < w_lev) && (w_s >= w_lev);
        end else begin
            w_hit = (w_p > w_lev) && (w_s <= w_lev);
        end
        // The edge is only looked for once per frame and needs a sample before it.
        w_trig_now = w_trig_mode && !r_triggered && r_have_prev && w_hit;

        if (w_trig_mode) begin
            w_active = r_triggered || w_trig_now;
            w_origin = w_trig_now ? r_frame_pos : r_trigger_pos;
        end else begin
            w_active = 1'b1;
            w_origin = '0;
        end

        w_valid = w_active && ((r_point_limit == '0) || (r_points < r_point_limit));
        w_off   = r_frame_pos - w_origin;

        // Scale by the point limit, or by what is left of the frame from the
        // origin. A frame shortened to or below the origin leaves no divisor.
        if (r_point_limit != '0) begin
            w_divisor = r_point_limit;
        end else if (w_len > w_origin) begin
            w_divisor = w_len - w_origin;
        end else begin
            w_divisor = '0;
        end

        // offset * 2^16 / divisor reaches 2^16 exactly when offset >= divisor,
        // so the quotient saturates without running the divider.
        w_sat  = (w_divisor == '0) || (w_off >= w_divisor);
        w_last = ({1'b0, r_frame_pos} + 1'b1) >= {1'b0, w_len};

        w_div_start = w_accept && w_valid && !w_sat;
    end

    // ------------------------------------------------------------------
    // Frame state, updated as each sample is accepted
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_have_prev   <= 1'b0;
            r_triggered   <= 1'b0;
            r_frame_pos   <= '0;
            r_trigger_pos <= '0;
            r_points      <= '0;
        end else if (w_accept) begin
            r_prev_sample <= i_sample;
            r_have_prev   <= 1'b1;
            if (w_last) begin
                r_frame_pos   <= '0;
                r_trigger_pos <= '0;
                r_triggered   <= 1'b0;
                r_points      <= '0;
            end else begin
                r_frame_pos <= r_frame_pos + 1'b1;
                if (w_trig_now) begin
                    r_triggered   <= 1'b1;
                    r_trigger_pos <= r_frame_pos;
                end
                if (w_valid) begin
                    r_points <= r_points + 1'b1;
                end
            end
        end
    end

    // Per-sample result fields that do not need the divider.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_valid_pt <= w_valid;
            r_last     <= w_last;
            r_sat      <= w_sat;
            r_y        <= i_sample[SAMPLE_BITS-1:1];
        end
    end

    // ------------------------------------------------------------------
    // Shared divider for the horizontal position
    // ------------------------------------------------------------------
    setp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rem     (w_off),
        .i_divisor (w_divisor),
        .o_status  (w_div_st),
        .o_quot    (w_quot)
    );

    assign w_q_final  = r_sat ? QUOT_SAT : w_quot;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else if (w_accept) begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_st.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Points that are not plotted report zero for both positions.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_point <= r_valid_pt;
            r_out_last  <= r_last;
            r_out_x     <= r_valid_pt ? (w_q_final ^ HALF_SCALE) : '0;
            r_out_y     <= r_valid_pt ? r_y : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_valid = r_out_point;
    assign o_x_pos       = signed'(r_out_x);
    assign o_y_pos       = signed'(r_out_y);
    assign o_frame_end   = r_out_last;

endmodule

>>> rtl/setp_checker.sv
// ============================================================================
// setp_checker: port-level checks for the edge trigger plotter
// Watches the top level's ports only and is bound to every instance.
// ============================================================================
module setp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_point_valid,
    input logic signed [setp_pkg::FRAC_W-1:0] o_x_pos,
    input logic signed [SAMPLE_BITS-2:0]      o_y_pos,
    input logic                               o_frame_end
);

    // A word held back by the receiver keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_x_pos)
            && $stable(o_y_pos) && $stable(o_point_valid) && $stable(o_frame_end))
        else $error("output word changed while stalled");

    // A sample that is not plotted carries zero positions.
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_point_valid |-> (o_x_pos == '0) && (o_y_pos == '0))
        else $error("unplotted word has non-zero position");

    // Each accepted sample occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // Reset leaves no word on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind scope_edge_trigger_plotter setp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_setp_checker (.*);

>>> test/scope_edge_trigger_plotter_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// scope_edge_trigger_plotter_checker: result predictor and scoreboard
// Follows configuration writes and accepted sample words, works out the
// point that each sample should give, and compares it with every result word
// taken from the block.
// ============================================================================
module scope_edge_trigger_plotter_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [15:0]                 i_sample,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_point_valid,
    input  logic signed [setp_pkg::FRAC_W-1:0] i_x_pos,
    input  logic signed [14:0]                 i_y_pos,
    input  logic                               i_frame_end,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [setp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [setp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import setp_pkg::*;

    localparam logic [POS_W-1:0] FRAME_CAP = 13'd4096;

    typedef struct packed {
        logic              point_valid;
        logic [FRAC_W-1:0] x_pos;
        logic [14:0]       y_pos;
        logic              frame_end;
    } t_plot_word;

    t_plot_word plot_q[$];
    int         fail_total = 0;
    int         pending_words = 0;

    // Register copies.
    logic [1:0]         slope_mode;
    logic signed [15:0] trig_level;
    logic [POS_W-1:0]   point_limit;
    logic [POS_W-1:0]   frame_length;

    // Frame state.
    logic signed [15:0] last_sample;
    logic               seen_sample;
    logic               armed;
    logic [POS_W-1:0]   frame_pos;
    logic [POS_W-1:0]   trig_pos;
    logic [POS_W-1:0]   points_done;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_words;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Works out the result word of one sample and advances the frame state.
    function automatic t_plot_word plot_sample(input logic signed [15:0] s);
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] origin;
        logic             active;
        logic             hit;
        logic [31:0]      offset;
        logic [31:0]      quot;
        t_plot_word       w;

        span = frame_length;
        if (span == '0) span = 13'd1;
        if (span > FRAME_CAP) span = FRAME_CAP;

        if (slope_mode == SLOPE_RISE || slope_mode == SLOPE_FALL) begin
            if (!armed && seen_sample) begin
                hit = (slope_mode == SLOPE_RISE)
                    ? (last_sample < trig_level && s >= trig_level)
                    : (last_sample > trig_level && s <= trig_level);
                if (hit) begin
                    armed    = 1'b1;
                    trig_pos = frame_pos;
                end
            end
            active = armed;
            origin = trig_pos;
        end else begin
            // Free running, and the unused code too, measure from frame start.
            active = 1'b1;
            origin = '0;
        end

        w = '0;
        w.point_valid = active && (point_limit == '0 || points_done < point_limit);
        if (w.point_valid) begin
            offset = {19'b0, frame_pos} - {19'b0, origin};
            if (point_limit != '0)
                quot = (offset << FRAC_W) / {19'b0, point_limit};
            else if (span > origin)
                quot = (offset << FRAC_W) / ({19'b0, span} - {19'b0, origin});
            else
                quot = {16'b0, QUOT_SAT};
            if (quot > {16'b0, QUOT_SAT}) quot = {16'b0, QUOT_SAT};
            w.x_pos = quot[FRAC_W-1:0] - HALF_SCALE;
            w.y_pos = s[15:1];
            points_done++;
        end

        w.frame_end = ({19'b0, frame_pos} + 32'd1) >= {19'b0, span};

        last_sample = s;
        seen_sample = 1'b1;
        if (w.frame_end) begin
            frame_pos   = '0;
            trig_pos    = '0;
            armed       = 1'b0;
            points_done = '0;
        end else begin
            frame_pos++;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_plot_word want;
        if (!i_rst_n) begin
            slope_mode   = SLOPE_FREE;
            trig_level   = '0;
            point_limit  = '0;
            frame_length = FRAME_LENGTH_RST;
            last_sample  = '0;
            seen_sample  = 1'b0;
            armed        = 1'b0;
            frame_pos    = '0;
            trig_pos     = '0;
            points_done  = '0;
            plot_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLOPE_MODE:    slope_mode   = i_cfg_data[1:0];
                    CFG_TRIGGER_LEVEL: trig_level   = i_cfg_data[LEVEL_W-1:0];
                    CFG_POINT_LIMIT:   point_limit  = i_cfg_data[POS_W-1:0];
                    CFG_FRAME_LENGTH:  frame_length = i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                plot_q.push_back(plot_sample(i_sample));
            if (i_out_valid && !i_out_stall) begin
                if (plot_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = plot_q.pop_front();
                    if (i_point_valid !== want.point_valid)
                        report_mismatch($sformatf("point_valid got %b expected %b",
                                                  i_point_valid, want.point_valid));
                    if (i_x_pos !== want.x_pos)
                        report_mismatch($sformatf("x_pos got %h expected %h",
                                                  i_x_pos, want.x_pos));
                    if (i_y_pos !== want.y_pos)
                        report_mismatch($sformatf("y_pos got %h expected %h",
                                                  i_y_pos, want.y_pos));
                    if (i_frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %b expected %b",
                                                  i_frame_end, want.frame_end));
                end
            end
        end
        pending_words <= plot_q.size();
    end

endmodule

>>> test/tb_scope_edge_trigger_plotter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_scope_edge_trigger_plotter: testbench of the edge trigger plotter
// Drives sample words and register settings into the block, with random
// gaps on the input and random stall on the output, and leaves prediction
// and comparison to the checker, which hands back a mismatch count.
// ============================================================================
module tb_scope_edge_trigger_plotter;
    import setp_pkg::*;

    // The fourth slope code has no name in the package; it must behave as
    // free running, so it gets a name of its own here.
    localparam logic [1:0] SLOPE_UNUSED = 2'd3;

    // Least number of random sample words sent before the long-frame run.
    localparam int RANDOM_WORDS = 380;

    // Sample words sent with the longest frame.
    localparam int LONG_WORDS = 40;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    in_valid    = 1'b0;
    logic signed [15:0]      sample      = '0;
    logic                    out_stall   = 1'b0;
    logic                    cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;

    logic                    in_stall;
    logic                    out_valid;
    logic                    point_valid;
    logic signed [FRAC_W-1:0] x_pos;
    logic signed [14:0]      y_pos;
    logic                    frame_end;
    logic                    cfg_ready;

    int                      fail_count;
    int                      pending;

    // When low, both sides run without any gap or stall.
    bit                      idling_on = 1'b1;

    scope_edge_trigger_plotter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample      (sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_point_valid (point_valid),
        .o_x_pos       (x_pos),
        .o_y_pos       (y_pos),
        .o_frame_end   (frame_end),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    scope_edge_trigger_plotter_checker i_plot_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_sample      (sample),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_point_valid (point_valid),
        .i_x_pos       (x_pos),
        .i_y_pos       (y_pos),
        .i_frame_end   (frame_end),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random on its own; the stall has no bearing on
    // what the sender does, so every phase of a point's work sees some.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= idling_on && ($urandom_range(99) < 23);
        end
    end

    // Hands one sample word to the block. Random gaps go before the word;
    // once valid is up, it and the payload stay put until the word is taken.
    task automatic send_sample(input logic [15:0] value);
        while (idling_on && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Holds the sender back until every word in flight has come out. The
    // first edge is needed because the checker's count of words in flight
    // is a registered copy of its queue size and trails the handshake.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Writes all four registers back to back. Only ever called while the
    // block has nothing in flight.
    task automatic set_regs(input logic [1:0]       mode,
                            input logic [15:0]      level,
                            input logic [POS_W-1:0] limit,
                            input logic [POS_W-1:0] length);
        cfg_write(CFG_SLOPE_MODE,    {14'b0, mode});
        cfg_write(CFG_TRIGGER_LEVEL, level);
        cfg_write(CFG_POINT_LIMIT,   {3'b0, limit});
        cfg_write(CFG_FRAME_LENGTH,  {3'b0, length});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int               sent;
        int               phase_no;
        int               count;
        int               k;
        int               lvl;
        int               amp;
        int               wave_lo;
        int               wave_hi;
        int               wave_cur;
        int               wave_dir;
        int               wave_step;
        bit               noisy;
        logic [1:0]       mode;
        logic [POS_W-1:0] limit;
        logic [POS_W-1:0] length;

        // Synchronous reset held low from the start, then never again.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------------------------------------------------------
        // Directed part.
        // Rising edge at level 100 on a frame of eight. The very first word
        // would cross the level if a previous sample counted, so it checks
        // that no trigger fires without one. The sample extremes follow.
        // The ninth word opens a new frame and triggers against the last
        // sample of the old one.
        // ---------------------------------------------------------------
        set_regs(SLOPE_RISE, 16'sd100, 13'd0, 13'd8);
        send_sample(16'sd200);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'sd0);
        send_sample(16'hFFFF);
        send_sample(16'sd1);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
        send_sample(16'sd100);
        drain;

        // The unused slope code runs free. A frame length of zero counts as
        // one, which also cuts the open frame short at once; the largest
        // point limit and the top trigger level are set at the same time.
        set_regs(SLOPE_UNUSED, 16'h7FFF, 13'h1FFF, 13'd0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'sd0);
        drain;

        // Trigger on the second word of a long frame, then shorten the frame
        // to one word so that the origin lies at the new end: the divisor is
        // no longer positive and the position must saturate.
        set_regs(SLOPE_RISE, 16'sd0, 13'd0, 13'd20);
        send_sample(-16'sd10);
        send_sample(16'sd10);
        send_sample(16'sd20);
        send_sample(16'sd30);
        drain;
        set_regs(SLOPE_RISE, 16'sd0, 13'd0, 13'd1);
        send_sample(16'sd40);
        drain;

        // Falling edge at the bottom level with a limit of one point, and a
        // later crossing that must not restart the trace.
        set_regs(SLOPE_FALL, 16'h8000, 13'd1, 13'd8);
        send_sample(16'sd5);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'sd7);
        send_sample(16'h8000);
        drain;

        // A switch to free running mid-frame measures from the frame start.
        set_regs(SLOPE_FREE, 16'hFFFF, 13'd4096, 13'd6);
        send_sample(16'sd1);
        send_sample(16'sd2);
        drain;

        // ---------------------------------------------------------------
        // Random part. Each phase picks new settings and then sends a
        // triangle wave that swings across the trigger level, sprinkled
        // with full-scale noise; some phases are noise alone. Phases do not
        // line up with frames, so settings change in the middle of frames,
        // and shorter frames catch the position already past the new end.
        // ---------------------------------------------------------------
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_WORDS) begin
            // A long stretch of phases with neither gaps nor stall.
            idling_on = !(phase_no >= 4 && phase_no <= 7);

            case ($urandom_range(9))
                0:             mode = SLOPE_FREE;
                1:             mode = SLOPE_UNUSED;
                2, 3, 4, 5:    mode = SLOPE_RISE;
                default:       mode = SLOPE_FALL;
            endcase
            case ($urandom_range(9))
                0, 1:    lvl = $urandom_range(1) ? 32767 : -32768;
                2:       lvl = 0;
                default: lvl = int'($urandom_range(40000)) - 20000;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3:    limit = '0;
                4, 5, 6, 7:    limit = POS_W'($urandom_range(1, 12));
                8:             limit = 13'd4096;
                default:       limit = 13'h1FFF;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: length = POS_W'($urandom_range(1, 24));
                7:                   length = '0;
                8:                   length = POS_W'($urandom_range(25, 200));
                default:             length = $urandom_range(1) ? 13'd4096 : 13'h1FFF;
            endcase
            set_regs(mode, 16'(lvl), limit, length);

            amp       = $urandom_range(1, 24000);
            wave_lo   = (lvl - amp < -32768) ? -32768 : lvl - amp;
            wave_hi   = (lvl + amp > 32767) ? 32767 : lvl + amp;
            wave_step = $urandom_range(1, amp);
            wave_cur  = wave_lo + int'($urandom_range(wave_hi - wave_lo));
            wave_dir  = $urandom_range(1) ? 1 : -1;
            noisy     = ($urandom_range(4) == 0);
            count     = $urandom_range(5, 40);

            for (k = 0; k < count; k++) begin
                if (noisy || $urandom_range(9) == 0) begin
                    send_sample(16'($urandom));
                end else begin
                    wave_cur = wave_cur + wave_dir * wave_step;
                    if (wave_cur >= wave_hi) begin
                        wave_cur = wave_hi;
                        wave_dir = -1;
                    end else if (wave_cur <= wave_lo) begin
                        wave_cur = wave_lo;
                        wave_dir = 1;
                    end
                    send_sample(16'(wave_cur));
                end
                // Once in the run the sender stops halfway through a phase
                // until every word in flight has come out.
                if (phase_no == 2 && k == count / 2) drain;
            end
            drain;
            sent += count;
            phase_no++;
        end
        idling_on = 1'b1;

        // ---------------------------------------------------------------
        // Longest frame: a length above the cap counts as the cap, and with
        // no point limit the position is scaled across the whole capped
        // frame.
        // ---------------------------------------------------------------
        set_regs(SLOPE_FREE, 16'sd0, 13'd0, 13'h1FFF);
        for (k = 0; k < LONG_WORDS; k++) send_sample(16'($urandom));
        drain;

        // Allow well over the time a plotted point takes for anything stray
        // to show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
